@@ sv/ilc_pkg.sv @@
// ----------------------------------------------------------------------------
// ilc_pkg: shared types and constants of the INI line classifier
// Line length limit, position width, result type codes and the structs that
// travel between the classifier modules.
// ----------------------------------------------------------------------------
package ilc_pkg;

    localparam int MAX_LINE_LENGTH = 255;
    // Wide enough to hold a position equal to the length limit.
    localparam int POS_W = $clog2(MAX_LINE_LENGTH + 1);

    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        LT_IGNORE  = 3'd0,
        LT_COMMENT = 3'd1,
        LT_SECTION = 3'd2,
        LT_INT     = 3'd3,
        LT_FLOAT   = 3'd4,
        LT_BOOL    = 3'd5,
        LT_STRING  = 3'd6
    } line_type_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       line_end;
    } item_t;

    typedef struct packed {
        line_type_t line_type;
        logic [7:0] name_start;
        logic [7:0] name_length;
        logic [7:0] value_start;
        logic [7:0] value_length;
        logic       overflow;
    } result_t;

    // Control from the line sequencer to the value typer.
    typedef struct packed {
        logic clear;
        logic pre_space;
        logic feed;
    } value_ctl_t;

endpackage

@@ sv/ilc_value_typer.sv @@
// ----------------------------------------------------------------------------
// ilc_value_typer: value type recognizer
// Runs the number, boolean word and quoted string recognizers over the value
// characters and reports the type the value has so far.
// ----------------------------------------------------------------------------
module ilc_value_typer (
    input  logic               clk,
    input  logic               rst_n,
    input  ilc_pkg::value_ctl_t ctl,
    input  logic [7:0]         ch,
    output ilc_pkg::line_type_t value_class
);
    import ilc_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_U     = 8'h55;

    typedef enum logic [2:0] {
        NUM_START = 3'd0,
        NUM_MINUS = 3'd1,
        NUM_INT   = 3'd2,
        NUM_DOT   = 3'd3,
        NUM_FRAC  = 3'd4,
        NUM_FAIL  = 3'd5
    } num_t;

    typedef enum logic [3:0] {
        WD_START = 4'd0,
        WD_T     = 4'd1,
        WD_TR    = 4'd2,
        WD_TRU   = 4'd3,
        WD_TRUE  = 4'd4,
        WD_F     = 4'd5,
        WD_FA    = 4'd6,
        WD_FAL   = 4'd7,
        WD_FALS  = 4'd8,
        WD_FALSE = 4'd9,
        WD_FAIL  = 4'd15
    } word_t;

    typedef enum logic [1:0] {
        QT_NONE   = 2'd0,
        QT_OPEN   = 2'd1,
        QT_CLOSED = 2'd2,
        QT_FAIL   = 2'd3
    } quote_t;

    function automatic num_t num_step(input num_t s, input logic [7:0] c);
        logic dig;
        num_t n;
        begin
            dig = (c >= CH_0) && (c <= CH_9);
            n = NUM_FAIL;
            unique case (s)
                NUM_START:
                begin
                    if (dig)              n = NUM_INT;
                    else if (c == CH_MINUS) n = NUM_MINUS;
                    else if (c == CH_DOT) n = NUM_DOT;
                end
                NUM_MINUS:
                begin
                    if (dig)              n = NUM_INT;
                    else if (c == CH_DOT) n = NUM_DOT;
                end
                NUM_INT:
                begin
                    if (dig)              n = NUM_INT;
                    else if (c == CH_DOT) n = NUM_FRAC;
                end
                NUM_DOT, NUM_FRAC:
                begin
                    if (dig) n = NUM_FRAC;
                end
                default: n = NUM_FAIL;
            endcase
            return n;
        end
    endfunction

    function automatic word_t word_step(input word_t s, input logic [7:0] c);
        word_t n;
        begin
            n = WD_FAIL;
            unique case (s)
                WD_START:
                begin
                    if (c == CH_T)      n = WD_T;
                    else if (c == CH_F) n = WD_F;
                end
                WD_T:    if (c == CH_R) n = WD_TR;
                WD_TR:   if (c == CH_U) n = WD_TRU;
                WD_TRU:  if (c == CH_E) n = WD_TRUE;
                WD_F:    if (c == CH_A) n = WD_FA;
                WD_FA:   if (c == CH_L) n = WD_FAL;
                WD_FAL:  if (c == CH_S) n = WD_FALS;
                WD_FALS: if (c == CH_E) n = WD_FALSE;
                default: n = WD_FAIL;
            endcase
            return n;
        end
    endfunction

    function automatic quote_t quote_step(input quote_t s, input logic [7:0] c);
        quote_t n;
        begin
            unique case (s)
                QT_NONE: n = (c == CH_QUOTE) ? QT_OPEN : QT_FAIL;
                QT_OPEN: n = (c == CH_QUOTE) ? QT_CLOSED : QT_OPEN;
                default: n = QT_FAIL;
            endcase
            return n;
        end
    endfunction

    num_t   num_reg,   num_next,   num_mid,   num_upd;
    word_t  word_reg,  word_next,  word_mid,  word_upd;
    quote_t quote_reg, quote_next, quote_mid, quote_upd;

    always_comb
    begin
        // A space held back inside the value is fed just before the next
        // non-space character.
        num_mid   = ctl.pre_space ? num_step(num_reg, CH_SPACE) : num_reg;
        word_mid  = ctl.pre_space ? word_step(word_reg, CH_SPACE) : word_reg;
        quote_mid = ctl.pre_space ? quote_step(quote_reg, CH_SPACE) : quote_reg;

        num_upd   = ctl.feed ? num_step(num_mid, ch) : num_mid;
        word_upd  = ctl.feed ? word_step(word_mid, ch) : word_mid;
        quote_upd = ctl.feed ? quote_step(quote_mid, ch) : quote_mid;

        priority if (num_upd == NUM_INT)
            value_class = LT_INT;
        else if (num_upd == NUM_FRAC)
            value_class = LT_FLOAT;
        else if (word_upd == WD_TRUE || word_upd == WD_FALSE)
            value_class = LT_BOOL;
        else if (quote_upd == QT_CLOSED)
            value_class = LT_STRING;
        else
            value_class = LT_IGNORE;

        num_next   = ctl.clear ? NUM_START : num_upd;
        word_next  = ctl.clear ? WD_START  : word_upd;
        quote_next = ctl.clear ? QT_NONE   : quote_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg   <= NUM_START;
            word_reg  <= WD_START;
            quote_reg <= QT_NONE;
        end
        else
        begin
            num_reg   <= num_next;
            word_reg  <= word_next;
            quote_reg <= quote_next;
        end
    end

endmodule

@@ sv/ilc_line_core.sv @@
// ----------------------------------------------------------------------------
// ilc_line_core: per-character line sequencer
// Tracks the line phase, positions and bracket state, drives the value typer
// and forms the classification result on the item that ends a line.
// ----------------------------------------------------------------------------
module ilc_line_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ilc_pkg::item_t   item,
    output ilc_pkg::result_t result,
    output logic             result_valid
);
    import ilc_pkg::*;

    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_COMMENT = 3'd1,
        PH_SECTION = 3'd2,
        PH_NAME    = 3'd3,
        PH_GAP     = 3'd4,
        PH_VALUE   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        BR_NONE = 2'd0,
        BR_LAST = 2'd1,
        BR_FAIL = 2'd2
    } bracket_t;

    // Positions and lengths leave the block as their low eight bits.
    function automatic logic [7:0] to_byte(input logic [POS_W-1:0] p);
        logic [31:0] w;
        begin
            w = 32'(p);
            return w[7:0];
        end
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next, pos_upd;
    phase_t           phase_reg, phase_next, phase_upd;
    logic [POS_W-1:0] name_last_reg, name_last_next, name_last_upd;
    logic             name_seen_reg, name_seen_next, name_seen_upd;
    logic [POS_W-1:0] value_first_reg, value_first_next, value_first_upd;
    logic [POS_W-1:0] value_last_reg, value_last_next, value_last_upd;
    logic             space_pending_reg, space_pending_next, space_pending_upd;
    bracket_t         bracket_reg, bracket_next, bracket_upd;
    logic             too_long_reg, too_long_next, too_long_upd;

    value_ctl_t       vctl;
    line_type_t       value_class;
    logic [7:0]       c;
    logic [7:0]       value_len;

    ilc_value_typer u_typer (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (vctl),
        .ch          (c),
        .value_class (value_class)
    );

    always_comb
    begin
        c                 = item.ch;
        pos_upd           = pos_reg;
        phase_upd         = phase_reg;
        name_last_upd     = name_last_reg;
        name_seen_upd     = name_seen_reg;
        value_first_upd   = value_first_reg;
        value_last_upd    = value_last_reg;
        space_pending_upd = space_pending_reg;
        bracket_upd       = bracket_reg;
        too_long_upd      = too_long_reg;
        vctl              = '0;

        if (step && item.has_char && !too_long_reg)
        begin
            if (pos_reg >= POS_W'(MAX_LINE_LENGTH))
            begin
                too_long_upd = 1'b1;
            end
            else
            begin
                pos_upd = pos_reg + 1'b1;
                unique case (phase_reg)
                    PH_START, PH_NAME:
                    begin
                        if (phase_reg == PH_START && c == CH_BANG)
                            phase_upd = PH_COMMENT;
                        else if (phase_reg == PH_START && c == CH_LBRACKET)
                            phase_upd = PH_SECTION;
                        else if (c == CH_EQUAL)
                            phase_upd = PH_GAP;
                        else
                        begin
                            phase_upd = PH_NAME;
                            if (c != CH_SPACE)
                            begin
                                name_seen_upd = 1'b1;
                                name_last_upd = pos_reg;
                            end
                        end
                    end
                    PH_COMMENT:
                    begin
                    end
                    PH_SECTION:
                    begin
                        if (bracket_reg == BR_NONE && c == CH_RBRACKET)
                            bracket_upd = BR_LAST;
                        else if (bracket_reg == BR_LAST)
                            bracket_upd = BR_FAIL;
                    end
                    PH_GAP:
                    begin
                        if (c != CH_SPACE)
                        begin
                            value_first_upd = pos_reg;
                            value_last_upd  = pos_reg;
                            vctl.feed       = 1'b1;
                            phase_upd       = PH_VALUE;
                        end
                    end
                    PH_VALUE:
                    begin
                        if (c == CH_SPACE)
                            space_pending_upd = 1'b1;
                        else
                        begin
                            vctl.pre_space    = space_pending_reg;
                            vctl.feed         = 1'b1;
                            space_pending_upd = 1'b0;
                            value_last_upd    = pos_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        result_valid = step && item.line_end;
        vctl.clear   = result_valid;

        value_len = to_byte(value_last_upd) - to_byte(value_first_upd) + 8'd1;
        result    = '0;
        if (too_long_upd)
        begin
            result.overflow = 1'b1;
        end
        else if (phase_upd == PH_COMMENT)
        begin
            result.line_type   = LT_COMMENT;
            result.name_start  = 8'd1;
            result.name_length = to_byte(pos_upd) - 8'd1;
        end
        else if (phase_upd == PH_SECTION && bracket_upd == BR_LAST)
        begin
            result.line_type   = LT_SECTION;
            result.name_start  = 8'd1;
            result.name_length = to_byte(pos_upd) - 8'd2;
        end
        else if (phase_upd == PH_VALUE && name_seen_upd && value_class != LT_IGNORE)
        begin
            result.line_type   = value_class;
            result.name_length = to_byte(name_last_upd) + 8'd1;
            if (value_class == LT_STRING)
            begin
                result.value_start  = to_byte(value_first_upd) + 8'd1;
                result.value_length = value_len - 8'd2;
            end
            else
            begin
                result.value_start  = to_byte(value_first_upd);
                result.value_length = value_len;
            end
        end

        // The line state starts over after every line end.
        pos_next           = result_valid ? '0       : pos_upd;
        phase_next         = result_valid ? PH_START : phase_upd;
        name_last_next     = result_valid ? '0       : name_last_upd;
        name_seen_next     = result_valid ? 1'b0     : name_seen_upd;
        value_first_next   = result_valid ? '0       : value_first_upd;
        value_last_next    = result_valid ? '0       : value_last_upd;
        space_pending_next = result_valid ? 1'b0     : space_pending_upd;
        bracket_next       = result_valid ? BR_NONE  : bracket_upd;
        too_long_next      = result_valid ? 1'b0     : too_long_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            phase_reg         <= PH_START;
            name_last_reg     <= '0;
            name_seen_reg     <= 1'b0;
            value_first_reg   <= '0;
            value_last_reg    <= '0;
            space_pending_reg <= 1'b0;
            bracket_reg       <= BR_NONE;
            too_long_reg      <= 1'b0;
        end
        else
        begin
            pos_reg           <= pos_next;
            phase_reg         <= phase_next;
            name_last_reg     <= name_last_next;
            name_seen_reg     <= name_seen_next;
            value_first_reg   <= value_first_next;
            value_last_reg    <= value_last_next;
            space_pending_reg <= space_pending_next;
            bracket_reg       <= bracket_next;
            too_long_reg      <= too_long_next;
        end
    end

endmodule

@@ sv/ini_line_classifier.sv @@
// Results: the item that ends a line passes the input register and then the
// result register; it stalls in the input register while a result waits.
// Throughput: one character per cycle while no line end waits on a pending
// result; the bound is the state update of the line sequencer and value typer.
// Reset: asynchronous, active low; clears all line state and both valid
// flags, and the block accepts characters right after reset.
// ----------------------------------------------------------------------------
// ini_line_classifier: INI text line classifier
// Takes one character per transfer and returns one classification result
// for every item that ends a line.
// ----------------------------------------------------------------------------
module ini_line_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       has_char,
    input  logic       line_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] line_type,
    output logic [7:0] name_start,
    output logic [7:0] name_length,
    output logic [7:0] value_start,
    output logic [7:0] value_length,
    output logic       overflow
);
    import ilc_pkg::*;

    item_t   item_reg, item_next;
    logic    item_valid_reg, item_valid_next;
    result_t result_reg, result_next;
    logic    out_valid_reg, out_valid_next;

    result_t core_result;
    logic    core_result_valid;
    logic    advance;
    logic    in_xfer;

    // A held character moves on unless it ends a line while the previous
    // result is still waiting.
    assign advance  = item_valid_reg && (!item_reg.line_end || !out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    ilc_line_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (item_reg),
        .result       (core_result),
        .result_valid (core_result_valid)
    );

    always_comb
    begin
        item_next       = in_xfer ? item_t'{ch: ch, has_char: has_char, line_end: line_end}
                                  : item_reg;
        item_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_reg);

        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (core_result_valid)
        begin
            result_next    = core_result;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign line_type    = result_reg.line_type;
    assign name_start   = result_reg.name_start;
    assign name_length  = result_reg.name_length;
    assign value_start  = result_reg.value_start;
    assign value_length = result_reg.value_length;
    assign overflow     = result_reg.overflow;

    a_overflow_is_ignore: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.overflow |->
            result_reg.line_type == LT_IGNORE && result_reg.name_start == 8'd0 &&
            result_reg.name_length == 8'd0 && result_reg.value_length == 8'd0)
        else $error("overflow result carries nonzero fields");

    a_comment_section_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg &&
        (result_reg.line_type == LT_COMMENT || result_reg.line_type == LT_SECTION) |->
            result_reg.name_start == 8'd1 && result_reg.value_start == 8'd0 &&
            result_reg.value_length == 8'd0)
        else $error("comment or section result has value fields");

    a_held_item_stable: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled character was lost or changed");

    a_line_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.line_end |=> out_valid_reg)
        else $error("line end did not produce a result");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        core_result_valid |-> !out_valid_reg || out_ready)
        else $error("pending result overwritten");

endmodule
